>>> rtl/ffud_pkg.sv
// Shared constants, types and helper functions for the form field URL decoder.
`timescale 1ns / 1ps

package ffud_pkg;

  localparam int unsigned MAX_KEY_LENGTH = 8;

  // Result queue depth and the most results one body byte can produce
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned MAX_ITEMS  = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_BYTES  = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_VALUE   = 2'd0;
  localparam logic [1:0] KIND_FOUND   = 2'd1;
  localparam logic [1:0] KIND_MISSING = 2'd2;

  // Parser phases
  localparam logic [1:0] PH_MATCH = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // Characters
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value_byte;
    logic       last;
  } ffud_item_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      v = b[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

>>> rtl/form_field_url_decoder_unit.sv
// Top level: extracts and percent-decodes one field of a URL-encoded form body.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid_i / in_stall_o) carries one body byte per
// transaction with last_byte_i marking the final byte of the body. The output
// channel (out_valid_o / out_stall_i) carries result items: decoded value
// bytes (kind 0) and one status item (kind 1 found, kind 2 not found) with
// last_o set at the end of each body.
// A byte lands in an input register, is parsed from there and its zero to
// four results are pushed at once into an eight-entry result queue that
// drains one item per cycle while the receiver does not stall. Throughput
// is one byte per cycle as long as each byte gives at most one result and
// the receiver does not stall; the input register holds while the queue has
// fewer than four free entries, so escape flushes stall the input. Reset
// empties the queue, clears the parser state and loads the default registers
// (key length 4, max value length 32, key zero). When the receiver stalls the
// head item holds and the queue fills until the input stalls too. Registers are
// written through cfg_we_i by the user only while idle; the block does not enforce it.

module form_field_url_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  body_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  value_byte_o,
  output logic        last_o
);

  localparam int unsigned NumCand = 5;

  // Configuration
  logic [63:0] key_bytes_q;
  logic [3:0]  key_length_q;
  logic [7:0]  max_len_q;

  // Input register
  logic       in_full_q;
  logic [7:0] byte_q;
  logic       last_q;

  // Parser state
  logic [1:0] phase_q, phase_d;
  logic [3:0] mpos_q, mpos_d;
  logic [1:0] pend_q, pend_d;
  logic [7:0] fhd_q, fhd_d;
  logic [7:0] cnt_q, cnt_d;
  logic       found_q, found_d;

  // Result queue
  ffud_pkg::ffud_item_t fifo_q [ffud_pkg::FIFO_DEPTH];
  logic [ffud_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ffud_pkg::CNT_W-1:0] count_q;

  ffud_pkg::ffud_item_t items [ffud_pkg::MAX_ITEMS];
  logic [2:0] n_push;

  logic fire, in_accept, pop;
  logic [3:0] kl;
  logic [7:0] kb;

  logic       cand_v [NumCand];
  logic [7:0] cand_b [NumCand];

  assign fire       = in_full_q && (count_q <= ffud_pkg::CNT_W'(ffud_pkg::FIFO_DEPTH -
                                                            ffud_pkg::MAX_ITEMS));
  assign in_stall_o = in_full_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  assign kl = (key_length_q > 4'(ffud_pkg::MAX_KEY_LENGTH)) ?
              4'(ffud_pkg::MAX_KEY_LENGTH) : key_length_q;
  assign kb = key_bytes_q[{mpos_q[2:0], 3'b000} +: 8];

  always_comb begin
    logic regular;
    phase_d = phase_q;
    mpos_d  = mpos_q;
    pend_d  = pend_q;
    fhd_d   = fhd_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    regular = 1'b0;
    n_push  = 3'd0;
    for (int i = 0; i < NumCand; i++) begin
      cand_v[i] = 1'b0;
      cand_b[i] = 8'h00;
    end
    for (int i = 0; i < ffud_pkg::MAX_ITEMS; i++) begin
      items[i] = '0;
    end

    unique case (phase_q)
      ffud_pkg::PH_MATCH: begin
        if (byte_q == ffud_pkg::CH_AMP) begin
          mpos_d = 4'd0;
        end else if (mpos_q < kl) begin
          if (byte_q == kb) begin
            mpos_d = mpos_q + 4'd1;
          end else begin
            phase_d = ffud_pkg::PH_SKIP;
          end
        end else if (byte_q == ffud_pkg::CH_EQUAL) begin
          found_d = 1'b1;
          phase_d = ffud_pkg::PH_VALUE;
          pend_d  = 2'd0;
          cnt_d   = 8'd0;
        end else begin
          phase_d = ffud_pkg::PH_SKIP;
        end
      end
      ffud_pkg::PH_SKIP: begin
        if (byte_q == ffud_pkg::CH_AMP) begin
          mpos_d  = 4'd0;
          phase_d = ffud_pkg::PH_MATCH;
        end
      end
      ffud_pkg::PH_VALUE: begin
        regular = 1'b1;
        if (pend_q == 2'd1) begin
          if (ffud_pkg::is_hex(byte_q)) begin
            fhd_d   = byte_q;
            pend_d  = 2'd2;
            regular = 1'b0;
          end else begin
            cand_v[0] = 1'b1;
            cand_b[0] = ffud_pkg::CH_PERCENT;
            pend_d    = 2'd0;
          end
        end else if (pend_q == 2'd2) begin
          cand_v[1] = 1'b1;
          if (ffud_pkg::is_hex(byte_q)) begin
            cand_b[1] = {ffud_pkg::hex_val(fhd_q), ffud_pkg::hex_val(byte_q)};
            regular   = 1'b0;
          end else begin
            cand_v[0] = 1'b1;
            cand_b[0] = ffud_pkg::CH_PERCENT;
            cand_b[1] = fhd_q;
          end
          pend_d = 2'd0;
        end
        if (regular) begin
          if (byte_q == ffud_pkg::CH_AMP) begin
            phase_d = ffud_pkg::PH_DONE;
          end else if (byte_q == ffud_pkg::CH_PLUS) begin
            cand_v[2] = 1'b1;
            cand_b[2] = ffud_pkg::CH_SPACE;
          end else if (byte_q == ffud_pkg::CH_PERCENT) begin
            pend_d = 2'd1;
          end else begin
            cand_v[2] = 1'b1;
            cand_b[2] = byte_q;
          end
        end
      end
      default: begin
        // value finished: ignore the rest of the body
      end
    endcase

    // Flush an escape cut off by the end of the body
    if (last_q && phase_d == ffud_pkg::PH_VALUE) begin
      cand_v[3] = (pend_d != 2'd0);
      cand_b[3] = ffud_pkg::CH_PERCENT;
      cand_v[4] = (pend_d == 2'd2);
      cand_b[4] = fhd_d;
      pend_d    = 2'd0;
    end

    // Pack value bytes in order, dropping those past the length limit
    for (int i = 0; i < NumCand; i++) begin
      if (cand_v[i] && cnt_d < max_len_q) begin
        items[n_push[1:0]] = '{kind: ffud_pkg::KIND_VALUE, value_byte: cand_b[i], last: 1'b0};
        n_push = n_push + 3'd1;
        cnt_d  = cnt_d + 8'd1;
      end
    end

    if (last_q) begin
      items[n_push[1:0]] = '{kind: found_d ? ffud_pkg::KIND_FOUND : ffud_pkg::KIND_MISSING,
                             value_byte: 8'h00, last: 1'b1};
      n_push  = n_push + 3'd1;
      phase_d = ffud_pkg::PH_MATCH;
      mpos_d  = 4'd0;
      pend_d  = 2'd0;
      fhd_d   = 8'h00;
      cnt_d   = 8'd0;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q  <= 64'd0;
      key_length_q <= 4'd4;
      max_len_q    <= 8'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ffud_pkg::REG_KEY_BYTES:  key_bytes_q  <= cfg_data_i;
        ffud_pkg::REG_KEY_LENGTH: key_length_q <= cfg_data_i[3:0];
        ffud_pkg::REG_MAX_LENGTH: max_len_q    <= cfg_data_i[7:0];
        default: begin
          // no register here: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_accept) begin
      in_full_q <= 1'b1;
    end else if (fire) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= body_byte_i;
      last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ffud_pkg::PH_MATCH;
      mpos_q  <= 4'd0;
      pend_q  <= 2'd0;
      fhd_q   <= 8'h00;
      cnt_q   <= 8'd0;
      found_q <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      mpos_q  <= mpos_d;
      pend_q  <= pend_d;
      fhd_q   <= fhd_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (fire) begin
        wr_ptr_q <= wr_ptr_q + ffud_pkg::PTR_W'(n_push);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + ffud_pkg::PTR_W'(1);
      end
      count_q <= count_q + (fire ? ffud_pkg::CNT_W'(n_push) : '0) -
                 ffud_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < ffud_pkg::MAX_ITEMS; i++) begin
        if (3'(i) < n_push) begin
          fifo_q[wr_ptr_q + ffud_pkg::PTR_W'(i)] <= items[i];
        end
      end
    end
  end

  assign out_valid_o  = (count_q != '0);
  assign kind_o       = fifo_q[rd_ptr_q].kind;
  assign value_byte_o = fifo_q[rd_ptr_q].value_byte;
  assign last_o       = fifo_q[rd_ptr_q].last;

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ffud_pkg::CNT_W'(ffud_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_value_implies_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ffud_pkg::PH_VALUE |-> found_q)
    else $error("inside value without a matched key");

  a_escape_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd0 |-> phase_q == ffud_pkg::PH_VALUE)
    else $error("escape pending outside value");

  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != ffud_pkg::KIND_VALUE |-> last_o && value_byte_o == 8'h00)
    else $error("malformed status item");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_q |=> phase_q == ffud_pkg::PH_MATCH && !found_q && cnt_q == 8'd0)
    else $error("state not cleared after end of body");

endmodule
